// File: hw/rtl/pwa_pkg.sv
// shared types and fixed-point constants for the polyphase wavelet analysis core
package pwa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int OUT_W    = 20;
  localparam int FRAC_SH  = 14;
  localparam int OUT_MAX  = 524287;
  localparam int OUT_MIN  = -524288;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic push;
    logic clear;
    logic issue;
    logic first;
  } hist_ctrl_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// File: hw/rtl/pwa_hist.sv
// circular sample delay line with per-entry valid bits and a walking read pointer
module pwa_hist #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pwa_pkg::hist_ctrl_t                   ctrl,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0]   push_data,
  output logic signed [pwa_pkg::SAMPLE_W-1:0]   rd_data
);

  localparam int TW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [pwa_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [TW-1:0]    head;
  logic [TW-1:0]    rptr;
  logic [TW-1:0]    head_next;
  logic [TW-1:0]    raddr;
  logic [TW-1:0]    raddr_dec;

  always_comb begin
    head_next = (head == TW'(DEPTH - 1)) ? '0 : head + TW'(1);
    raddr     = ctrl.first ? head : rptr;
    raddr_dec = (raddr == '0) ? TW'(DEPTH - 1) : raddr - TW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      rptr  <= '0;
      valid <= '0;
    end else begin
      if (ctrl.clear) begin
        valid <= '0;
      end else if (ctrl.push) begin
        valid[head_next] <= 1'b1;
      end
      if (ctrl.push) begin
        head <= head_next;
      end
      if (ctrl.issue) begin
        rptr <= raddr_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[head_next] <= push_data;
    end
    if (ctrl.issue) begin
      rd_data <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

// File: hw/rtl/pwa_lane.sv
// one coefficient bank with its multiply-accumulate pipeline
module pwa_lane #(
  parameter int DEPTH = 16,
  parameter int AW    = 36
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic signed [pwa_pkg::COEF_W-1:0]             wr_data,
  input  pwa_pkg::mac_ctrl_t                            ctrl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0]           sample,
  output logic signed [AW-1:0]                          acc,
  output logic                                          done
);

  logic signed [pwa_pkg::COEF_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                  cvalid;
  logic signed [pwa_pkg::COEF_W-1:0] coef_q;
  logic signed [pwa_pkg::PROD_W-1:0] prod;
  pwa_pkg::mac_ctrl_t                s1;
  pwa_pkg::mac_ctrl_t                s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      s1     <= '0;
      s2     <= '0;
      done   <= 1'b0;
    end else begin
      if (wr_en) begin
        cvalid[wr_addr] <= 1'b1;
      end
      s1   <= ctrl;
      s2   <= s1;
      done <= s2.issue & s2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.issue) begin
      coef_q <= cvalid[rd_addr] ? mem[rd_addr] : '0;
    end
    if (s1.issue) begin
      prod <= coef_q * sample;
    end
    if (s2.issue) begin
      acc <= s2.first ? AW'(prod) : acc + AW'(prod);
    end
  end

endmodule

// File: hw/rtl/pwa_merge.sv
// lane merge: phase sums, scaling, saturation and the output register
module pwa_merge #(
  parameter int AW = 36
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 done,
  input  logic signed [AW-1:0]                 acc [pwa_pkg::NUM_LANES],
  input  logic                                 last_in,
  input  logic                                 out_stall,
  output logic                                 loaded,
  output logic                                 out_valid,
  output logic signed [pwa_pkg::OUT_W-1:0]     approx,
  output logic signed [pwa_pkg::OUT_W-1:0]     detail,
  output logic                                 last
);

  localparam int SW = AW + 1;
  localparam int HW = SW - pwa_pkg::FRAC_SH;
  localparam int EW = (HW > pwa_pkg::OUT_W + 1) ? HW : pwa_pkg::OUT_W + 1;

  logic signed [SW-1:0] sa;
  logic signed [SW-1:0] sd;
  logic                 sv;
  logic signed [EW-1:0] qa;
  logic signed [EW-1:0] qd;
  logic signed [EW-1:0] ca;
  logic signed [EW-1:0] cd;

  assign loaded = sv;

  always_comb begin
    qa = EW'($signed(sa[SW-1:pwa_pkg::FRAC_SH]));
    qd = EW'($signed(sd[SW-1:pwa_pkg::FRAC_SH]));
    if (qa > EW'(pwa_pkg::OUT_MAX)) begin
      ca = EW'(pwa_pkg::OUT_MAX);
    end else if (qa < EW'(pwa_pkg::OUT_MIN)) begin
      ca = EW'(pwa_pkg::OUT_MIN);
    end else begin
      ca = qa;
    end
    if (qd > EW'(pwa_pkg::OUT_MAX)) begin
      cd = EW'(pwa_pkg::OUT_MAX);
    end else if (qd < EW'(pwa_pkg::OUT_MIN)) begin
      cd = EW'(pwa_pkg::OUT_MIN);
    end else begin
      cd = qd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sv <= done;
      if (sv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      sa <= SW'(acc[0]) + SW'(acc[1]);
      sd <= SW'(acc[2]) + SW'(acc[3]);
    end
    if (sv) begin
      approx <= ca[pwa_pkg::OUT_W-1:0];
      detail <= cd[pwa_pkg::OUT_W-1:0];
      last   <= last_in;
    end
  end

endmodule

// File: hw/rtl/polyphase_wavelet_analysis_core.sv
// top level: request sequencer, delay lines, four bank lanes and the merge stage
//
// One level of a two-channel polyphase wavelet analysis bank. Let n be tap_count
// clamped to 1..MAX_TAPS. A sample pair produces one approximation/detail
// transfer: the four bank lanes each run one multiply-accumulate per tap for n
// taps, followed by a pipeline drain through the product, accumulate, sum and
// saturate registers. A flush produces n-1 tail transfers, the final one marked
// by last, and clears both delay lines. New requests are taken only after the
// previous one has finished, while its last result may still be waiting at the
// output.
module polyphase_wavelet_analysis_core #(
  parameter int MAX_TAPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [4:0]                          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [1:0]                          coef_bank,
  input  logic [3:0]                          coef_tap,
  input  logic signed [pwa_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0] even_sample,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0] odd_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pwa_pkg::OUT_W-1:0]    approx,
  output logic signed [pwa_pkg::OUT_W-1:0]    detail,
  output logic                                last
);

  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int NW = 7;
  localparam int AW = pwa_pkg::PROD_W + $clog2(MAX_TAPS);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PAIR  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]                          state;
  logic [4:0]                          tap_count;
  logic [CW-1:0]                       cnt;
  logic [CW-1:0]                       tail;
  logic                                flushing;
  logic                                last_flag;
  logic signed [pwa_pkg::SAMPLE_W-1:0] even_q;
  logic signed [pwa_pkg::SAMPLE_W-1:0] odd_q;

  logic [CW-1:0]       n;
  logic                in_xfer;
  logic                tap_ok;
  logic                loaded;
  logic                all_done;
  pwa_pkg::hist_ctrl_t hctrl;
  pwa_pkg::mac_ctrl_t  mctrl;
  logic signed [pwa_pkg::SAMPLE_W-1:0] even_rd;
  logic signed [pwa_pkg::SAMPLE_W-1:0] odd_rd;
  logic signed [AW-1:0] acc [pwa_pkg::NUM_LANES];
  logic [pwa_pkg::NUM_LANES-1:0] done;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign tap_ok   = {3'b000, coef_tap} < NW'(MAX_TAPS);
  assign all_done = &done;

  always_comb begin
    if (tap_count == 5'd0) begin
      n = CW'(1);
    end else if ({2'b00, tap_count} > NW'(MAX_TAPS)) begin
      n = CW'(MAX_TAPS);
    end else begin
      n = CW'(tap_count);
    end
  end

  always_comb begin
    hctrl       = '0;
    mctrl       = '0;
    hctrl.push  = (state == S_PUSH);
    hctrl.issue = (state == S_MAC);
    hctrl.first = (state == S_MAC) && (cnt == '0);
    mctrl.issue = hctrl.issue;
    mctrl.first = hctrl.first;
    mctrl.last  = (state == S_MAC) && (cnt == n - CW'(1));
    if (in_xfer && req_type == REQ_FLUSH && n == CW'(1)) begin
      hctrl.clear = 1'b1;
    end
    if (state == S_DRAIN && loaded && flushing && tail == CW'(1)) begin
      hctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= 5'd16;
      cnt       <= '0;
      tail      <= '0;
      flushing  <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (req_type)
              REQ_PAIR: begin
                flushing  <= 1'b0;
                last_flag <= 1'b0;
                state     <= S_WAIT;
              end
              REQ_FLUSH: begin
                if (n != CW'(1)) begin
                  flushing  <= 1'b1;
                  tail      <= n - CW'(1);
                  last_flag <= (n == CW'(2));
                  state     <= S_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WAIT: begin
          if (!out_valid || !out_stall) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          cnt   <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          cnt <= cnt + CW'(1);
          if (cnt == n - CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (loaded) begin
            if (flushing && tail != CW'(1)) begin
              tail      <= tail - CW'(1);
              last_flag <= (tail == CW'(2));
              state     <= S_WAIT;
            end else begin
              flushing <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (req_type == REQ_PAIR) begin
        even_q <= even_sample;
        odd_q  <= odd_sample;
      end else if (req_type == REQ_FLUSH) begin
        even_q <= '0;
        odd_q  <= '0;
      end
    end
  end

  pwa_hist #(.DEPTH(MAX_TAPS)) u_hist_even (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hctrl),
    .push_data (even_q),
    .rd_data   (even_rd)
  );

  pwa_hist #(.DEPTH(MAX_TAPS)) u_hist_odd (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hctrl),
    .push_data (odd_q),
    .rd_data   (odd_rd)
  );

  for (genvar g = 0; g < pwa_pkg::NUM_LANES; g++) begin : g_lane
    pwa_lane #(.DEPTH(MAX_TAPS), .AW(AW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (in_xfer && req_type == REQ_LOAD && coef_bank == 2'(g) && tap_ok),
      .wr_addr (TW'(coef_tap)),
      .wr_data (coef_value),
      .ctrl    (mctrl),
      .rd_addr (cnt[TW-1:0]),
      .sample  (((g % 2) == 0) ? even_rd : odd_rd),
      .acc     (acc[g]),
      .done    (done[g])
    );
  end

  pwa_merge #(.AW(AW)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .done      (all_done),
    .acc       (acc),
    .last_in   (last_flag),
    .out_stall (out_stall),
    .loaded    (loaded),
    .out_valid (out_valid),
    .approx    (approx),
    .detail    (detail),
    .last      (last)
  );

endmodule

// File: dv/pwa_tb_pkg.sv
// request and bank codes plus the output record shared by the wavelet bench
package pwa_tb_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_PAIR   = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    BANK_EVEN_APPROX = 2'd0,
    BANK_ODD_APPROX  = 2'd1,
    BANK_EVEN_DETAIL = 2'd2,
    BANK_ODD_DETAIL  = 2'd3
  } coef_bank_e;

  typedef struct packed {
    logic signed [pwa_pkg::OUT_W-1:0] approx;
    logic signed [pwa_pkg::OUT_W-1:0] detail;
    logic                             last;
  } wavelet_coeff_t;

endpackage

// File: dv/pwa_checker.sv
// watches the wavelet core channels, predicts each coefficient pair and compares
module pwa_checker #(
  parameter int MAX_TAPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [4:0]                          cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [1:0]                          coef_bank,
  input  logic [3:0]                          coef_tap,
  input  logic signed [pwa_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0] even_sample,
  input  logic signed [pwa_pkg::SAMPLE_W-1:0] odd_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [pwa_pkg::OUT_W-1:0]    approx,
  input  logic signed [pwa_pkg::OUT_W-1:0]    detail,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  compared,
  output logic                                drained
);
  import pwa_tb_pkg::*;

  logic [4:0]         tap_reg;
  logic signed [15:0] even_line [MAX_TAPS];
  logic signed [15:0] odd_line [MAX_TAPS];
  logic signed [15:0] coef_mem [4*MAX_TAPS];
  wavelet_coeff_t     expected_coeffs [$];
  int                 err_cnt = 0;
  int                 cmp_cnt = 0;

  function automatic int active_taps();
    if (tap_reg == 5'd0) return 1;
    if (tap_reg > MAX_TAPS) return MAX_TAPS;
    return int'(tap_reg);
  endfunction

  function automatic void shift_in(logic signed [15:0] ev, logic signed [15:0] od);
    for (int k = MAX_TAPS - 1; k > 0; k--) begin
      even_line[k] = even_line[k-1];
      odd_line[k]  = odd_line[k-1];
    end
    even_line[0] = ev;
    odd_line[0]  = od;
  endfunction

  function automatic void clear_lines();
    for (int k = 0; k < MAX_TAPS; k++) begin
      even_line[k] = '0;
      odd_line[k]  = '0;
    end
  endfunction

  // both phases summed exactly, floor shift, then clamp to the output range
  function automatic logic signed [pwa_pkg::OUT_W-1:0] bank_output(int bank_e, int bank_o);
    longint acc;
    longint q;
    acc = 0;
    for (int i = 0; i < active_taps(); i++) begin
      acc += longint'(coef_mem[bank_e*MAX_TAPS+i]) * longint'(even_line[i]);
      acc += longint'(coef_mem[bank_o*MAX_TAPS+i]) * longint'(odd_line[i]);
    end
    q = acc >>> pwa_pkg::FRAC_SH;
    if (q > pwa_pkg::OUT_MAX) q = pwa_pkg::OUT_MAX;
    if (q < pwa_pkg::OUT_MIN) q = pwa_pkg::OUT_MIN;
    return q[pwa_pkg::OUT_W-1:0];
  endfunction

  function automatic void predict_coeffs(logic is_last);
    wavelet_coeff_t c;
    c.approx = bank_output(BANK_EVEN_APPROX, BANK_ODD_APPROX);
    c.detail = bank_output(BANK_EVEN_DETAIL, BANK_ODD_DETAIL);
    c.last   = is_last;
    expected_coeffs.push_back(c);
  endfunction

  function automatic void apply_request();
    int tail;
    case (req_type)
      REQ_LOAD: begin
        if (coef_tap < MAX_TAPS) coef_mem[int'(coef_bank)*MAX_TAPS + int'(coef_tap)] = coef_value;
      end
      REQ_PAIR: begin
        shift_in(even_sample, odd_sample);
        predict_coeffs(1'b0);
      end
      REQ_FLUSH: begin
        tail = active_taps() - 1;
        for (int k = 0; k < tail; k++) begin
          shift_in('0, '0);
          predict_coeffs(k == tail - 1);
        end
        clear_lines();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : track
    wavelet_coeff_t want;
    if (rst) begin
      tap_reg = 5'd16;
      clear_lines();
      for (int i = 0; i < 4*MAX_TAPS; i++) coef_mem[i] = '0;
      expected_coeffs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_coeffs.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer approx %0d detail %0d last %0b",
                   $time, approx, detail, last);
        end else begin
          want = expected_coeffs.pop_front();
          cmp_cnt++;
          if (approx !== want.approx) begin
            err_cnt++;
            $display("%0t: approx expected %0d actual %0d", $time, $signed(want.approx), approx);
          end
          if (detail !== want.detail) begin
            err_cnt++;
            $display("%0t: detail expected %0d actual %0d", $time, $signed(want.detail), detail);
          end
          if (last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
          end
        end
      end
      if (cfg_wr_en) tap_reg = cfg_wr_data;
      if (in_valid && !in_stall) apply_request();
    end
    drained    <= (expected_coeffs.size() == 0);
    fail_count <= err_cnt;
    compared   <= cmp_cnt;
  end

endmodule

// File: dv/tb_polyphase_wavelet_analysis_core.sv
// stimulus, flow control and verdict for the polyphase wavelet analysis core
module tb_polyphase_wavelet_analysis_core;
  import pwa_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 36;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_wr_en = 1'b0;
  logic [4:0]                          cfg_wr_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          req_type = '0;
  logic [1:0]                          coef_bank = '0;
  logic [3:0]                          coef_tap = '0;
  logic signed [pwa_pkg::COEF_W-1:0]   coef_value = '0;
  logic signed [pwa_pkg::SAMPLE_W-1:0] even_sample = '0;
  logic signed [pwa_pkg::SAMPLE_W-1:0] odd_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [pwa_pkg::OUT_W-1:0]    approx;
  logic signed [pwa_pkg::OUT_W-1:0]    detail;
  logic                                last;

  int   fail_count;
  int   compared;
  logic drained;
  bit   no_idle = 1'b0;
  bit   hold_output = 1'b0;
  int   n_pairs = 0;
  int   n_loads = 0;
  int   n_flushes = 0;
  int   n_unused = 0;
  int   n_settings = 0;
  int   idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  polyphase_wavelet_analysis_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .coef_bank   (coef_bank),
    .coef_tap    (coef_tap),
    .coef_value  (coef_value),
    .even_sample (even_sample),
    .odd_sample  (odd_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .approx      (approx),
    .detail      (detail),
    .last        (last)
  );

  pwa_checker coeff_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .coef_bank   (coef_bank),
    .coef_tap    (coef_tap),
    .coef_value  (coef_value),
    .even_sample (even_sample),
    .odd_sample  (odd_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .approx      (approx),
    .detail      (detail),
    .last        (last),
    .fail_count  (fail_count),
    .compared    (compared),
    .drained     (drained)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_polyphase_wavelet_analysis_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer_request(input req_kind_e kind, input logic [1:0] bank,
                               input logic [3:0] tap, input logic [15:0] cval,
                               input logic [15:0] ev, input logic [15:0] od);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    coef_bank   <= bank;
    coef_tap    <= tap;
    coef_value  <= cval;
    even_sample <= ev;
    odd_sample  <= od;
    do @(posedge clk); while (in_stall);
    case (kind)
      REQ_LOAD:  n_loads++;
      REQ_PAIR:  n_pairs++;
      REQ_FLUSH: n_flushes++;
      default:   n_unused++;
    endcase
  endtask

  task automatic load_coef(input coef_bank_e bank, input logic [3:0] tap, input logic [15:0] cval);
    offer_request(REQ_LOAD, bank, tap, cval, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_pair(input logic [15:0] ev, input logic [15:0] od);
    offer_request(REQ_PAIR, 2'($urandom), 4'($urandom), 16'($urandom), ev, od);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (!drained);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [4:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input int count);
    int          pick;
    logic [15:0] cval;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       cval = 16'($urandom);
        1:       cval = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: cval = 16'($urandom_range(0, 8191) - 4096);
      endcase
      if (pick < 68) begin
        send_pair(16'($urandom), 16'($urandom));
      end else if (pick < 88) begin
        offer_request(REQ_LOAD, 2'($urandom), 4'($urandom), cval,
                      16'($urandom), 16'($urandom));
      end else if (pick < 96) begin
        offer_request(REQ_FLUSH, 2'($urandom), 4'($urandom), cval,
                      16'($urandom), 16'($urandom));
      end else begin
        offer_request(REQ_UNUSED, 2'($urandom), 4'($urandom), cval,
                      16'($urandom), 16'($urandom));
      end
    end
    offer_request(REQ_FLUSH, 2'($urandom), 4'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
  endtask

  // output side: random stall per transfer, or one long hold when asked
  initial begin : out_side
    int wait_cycles;
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        out_stall <= 1'b0;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table gives zero out
    send_pair(16'sh7FFF, 16'sh8000);
    for (int t = 0; t < 4; t++) begin
      load_coef(BANK_EVEN_APPROX, 4'(t), 16'h8000);
      load_coef(BANK_ODD_APPROX, 4'(t), 16'h8000);
    end
    load_coef(BANK_EVEN_DETAIL, 4'd15, 16'h7FFF);
    load_coef(BANK_ODD_DETAIL, 4'd15, 16'h8000);
    // full-scale negative samples drive approx into positive saturation
    repeat (4) send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'hFFFF, 16'h0001);
    offer_request(REQ_UNUSED, BANK_ODD_DETAIL, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_request(REQ_FLUSH, BANK_EVEN_APPROX, 4'd0, 16'h0000, 16'h0000, 16'h0000);

    write_tap_count(5'd1);
    random_phase(PHASE_ITEMS);
    write_tap_count(5'd0);
    random_phase(PHASE_ITEMS);
    write_tap_count(5'd31);
    random_phase(PHASE_ITEMS);
    write_tap_count(5'd17);
    hold_output = 1'b1;
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    no_idle = 1'b0;
    write_tap_count(5'd2);
    random_phase(PHASE_ITEMS);
    write_tap_count(5'($urandom_range(3, 15)));
    random_phase(PHASE_ITEMS);
    write_tap_count(5'd16);
    random_phase(PHASE_ITEMS);
    settle();

    $display("run covered %0d sample pairs, %0d loads, %0d flushes, %0d reserved requests",
             n_pairs, n_loads, n_flushes, n_unused);
    $display("over %0d tap settings plus reset, %0d output transfers compared, one long hold",
             n_settings, compared);
    if (fail_count == 0) begin
      $display("tb_polyphase_wavelet_analysis_core: clean");
    end else begin
      $display("tb_polyphase_wavelet_analysis_core: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pwa_pkg.sv
hw/rtl/pwa_hist.sv
hw/rtl/pwa_lane.sv
hw/rtl/pwa_merge.sv
hw/rtl/polyphase_wavelet_analysis_core.sv
dv/pwa_tb_pkg.sv
dv/pwa_checker.sv
dv/tb_polyphase_wavelet_analysis_core.sv
